[src/ptbd_pkg.sv]
// shared types, codes and font table for the page framebuffer draw engine
package ptbd_pkg;

   // command codes on the request channel
   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_PIXEL = 3'd1,
      CMD_TEXT  = 3'd2,
      CMD_BAR   = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // what the back end has to do with one queued job
   typedef enum logic [1:0] {
      JOB_NOP,
      JOB_CLEAR,
      JOB_DRAW,
      JOB_READ
   } job_kind_type;

   // where the column pattern of a draw job comes from
   typedef enum logic [1:0] {
      STYLE_PIXEL,
      STYLE_GLYPH,
      STYLE_BAR
   } draw_style_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_COL,
      ST_WR,
      ST_RDBYTE,
      ST_CLEAR,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic        pixel_on;
      logic        text_start;
      logic [7:0]  char_code;
      logic [7:0]  bar_width;
      logic [16:0] bar_fraction;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       char_fit;
   } rsp_type;

   typedef struct packed {
      job_kind_type   kind;
      draw_style_type style;
      logic [7:0]     x;
      logic [7:0]     y;
      logic [7:0]     count;
      logic [2:0]     nrows;
      logic [7:0]     aux;
      logic           fit;
      logic [9:0]     read_index;
   } job_type;

   localparam int          QUEUE_DEPTH = 2;
   localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int          INDEX_W     = 14;
   localparam logic [7:0]  GLYPH_COLS  = 8'd5;
   localparam logic [2:0]  GLYPH_ROWS  = 3'd7;
   localparam logic [2:0]  BAR_ROWS    = 3'd6;
   localparam logic [7:0]  CURSOR_STEP = 8'd6;
   localparam logic [8:0]  CURSOR_SPAN = 9'd5;
   localparam logic [16:0] FRAC_ONE    = 17'h10000;
   localparam logic [2:0]  GLYPH_BASE  = 3'b001;

   // 5x7 font for codes 32..63, one byte per column, bit 0 on top
   localparam logic [7:0] GLYPH_ROM [32][5] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
      '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00}, '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
      '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
      '{8'h36, 8'h49, 8'h56, 8'h20, 8'h50}, '{8'h00, 8'h08, 8'h07, 8'h03, 8'h00},
      '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00}, '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
      '{8'h2A, 8'h1C, 8'h7F, 8'h1C, 8'h2A}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
      '{8'h00, 8'h80, 8'h70, 8'h30, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
      '{8'h00, 8'h00, 8'h60, 8'h60, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31}, '{8'h41, 8'h21, 8'h11, 8'h09, 8'h07},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E},
      '{8'h00, 8'h00, 8'h14, 8'h00, 8'h00}, '{8'h00, 8'h40, 8'h34, 8'h00, 8'h00},
      '{8'h00, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
      '{8'h00, 8'h41, 8'h22, 8'h14, 8'h08}, '{8'h02, 8'h01, 8'h59, 8'h09, 8'h06}
   };

   function automatic logic [7:0] glyph_column(input logic [4:0] idx, input logic [2:0] col);
      logic [7:0] bits;
      bits = 8'h00;
      if (col < 3'd5) begin
         bits = GLYPH_ROM[idx][col];
      end
      return bits;
   endfunction

endpackage

[src/page_framebuffer_text_bar_draw.sv]
// top level of the page framebuffer draw engine: front end, job queue, back end
// every item goes from intake through the job queue and back end to the result register;
// draws work column by column and page byte by page byte, a clear writes the whole frame
// the back end takes one item at a time and does a read-modify-write of each touched
// page byte in the frame memory
// reset: synchronous; afterwards a clearing pass over all DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8)
// frame bytes (1024 by default) zeroes the frame while req_stall stays high
module page_framebuffer_text_bar_draw #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptbd_pkg::rsp_type rsp_data
);
   import ptbd_pkg::*;

   // front to queue
   logic    q_push;
   job_type push_job;
   logic    q_full;
   // queue to back
   logic    q_pop;
   logic    q_not_empty;
   job_type head_job;
   // back end still clearing the frame after reset
   logic    init_busy;

   // command decode, cursor tracking and bar fill length
   ptbd_front #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // decouples intake from the slow memory sequencer
   ptbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   // frame memory and per-byte read-modify-write, result register at the output
   ptbd_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/ptbd_front.sv]
// front end: accepts commands, tracks the text cursor and turns each item into a job
module ptbd_front #(
   parameter int DISPLAY_WIDTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptbd_pkg::req_type req_data,
   input  logic              init_busy,
   input  logic              q_full,
   output logic              q_push,
   output ptbd_pkg::job_type q_job
);
   import ptbd_pkg::*;

   logic [7:0]  cursor_col_ff, cursor_col_in;
   logic [7:0]  cursor_row_ff, cursor_row_in;
   logic [7:0]  base_col, base_row;
   logic        fit;
   logic [16:0] frac_sat;
   logic [24:0] fill_prod;
   logic        accept;

   assign req_stall = init_busy | q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = accept;

   // bar fill length, fraction saturated to one
   assign frac_sat  = (req_data.bar_fraction > FRAC_ONE) ? FRAC_ONE : req_data.bar_fraction;
   assign fill_prod = 25'(frac_sat) * 25'(req_data.bar_width);

   always_comb begin
      base_col = req_data.text_start ? req_data.pos_x : cursor_col_ff;
      base_row = req_data.text_start ? req_data.pos_y : cursor_row_ff;
      fit      = ({1'b0, base_col} + CURSOR_SPAN) < 9'(DISPLAY_WIDTH);
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      q_job = '0;
      q_job.kind  = JOB_NOP;
      q_job.style = STYLE_PIXEL;
      case (req_data.cmd)
         CMD_CLEAR: begin
            q_job.kind = JOB_CLEAR;
         end
         CMD_PIXEL: begin
            q_job.kind  = JOB_DRAW;
            q_job.style = STYLE_PIXEL;
            q_job.x     = req_data.pos_x;
            q_job.y     = req_data.pos_y;
            q_job.count = 8'd1;
            q_job.nrows = 3'd1;
            q_job.aux   = {7'd0, req_data.pixel_on};
         end
         CMD_TEXT: begin
            q_job.fit = fit;
            if (fit && req_data.char_code[7:5] == GLYPH_BASE) begin
               q_job.kind  = JOB_DRAW;
               q_job.style = STYLE_GLYPH;
               q_job.x     = base_col;
               q_job.y     = base_row;
               q_job.count = GLYPH_COLS;
               q_job.nrows = GLYPH_ROWS;
               q_job.aux   = {3'd0, req_data.char_code[4:0]};
            end
            if (accept) begin
               cursor_col_in = fit ? base_col + CURSOR_STEP : base_col;
               cursor_row_in = base_row;
            end
         end
         CMD_BAR: begin
            if (req_data.bar_width != 8'd0) begin
               q_job.kind  = JOB_DRAW;
               q_job.style = STYLE_BAR;
               q_job.x     = req_data.pos_x;
               q_job.y     = req_data.pos_y;
               q_job.count = req_data.bar_width;
               q_job.nrows = BAR_ROWS;
               q_job.aux   = fill_prod[23:16];
            end
         end
         CMD_READ: begin
            q_job.kind       = JOB_READ;
            q_job.read_index = req_data.read_index;
         end
         default: begin
            q_job.kind = JOB_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

[src/ptbd_queue.sv]
// short job queue between the front and back ends
module ptbd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptbd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ptbd_pkg::job_type head_job
);
   import ptbd_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[src/ptbd_back.sv]
// back end: frame memory, column read-modify-write sequencer and result register
module ptbd_back #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ptbd_pkg::job_type q_job,
   output logic              q_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptbd_pkg::rsp_type rsp_data
);
   import ptbd_pkg::*;

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int AW          = $clog2(FRAME_BYTES);

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [7:0]     col_ff, col_in;
   logic           half_ff, half_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [7:0]     mask_ff, mask_in;
   logic [7:0]     val_ff, val_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic [7:0]     rd_data_ff;

   logic [7:0]     mem [FRAME_BYTES];

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [7:0]        wr_data;
   logic [7:0]        col_x, last_row, pattern, row_b, rel_b;
   logic [4:0]        page0, page1, cur_page;
   logic              two_pages, col_ok, last_byte, last_col, do_advance;
   logic [7:0]        cur_mask, cur_val;
   logic [INDEX_W-1:0] lin_idx, read_idx;
   logic [AW-1:0]     cur_addr;
   logic              read_in_range;

   assign init_busy = state_ff == ST_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // column datapath: one page byte of the current column
   always_comb begin
      col_x     = job_ff.x + col_ff;
      last_row  = job_ff.y + 8'(job_ff.nrows) - 8'd1;
      page0     = job_ff.y[7:3];
      page1     = last_row[7:3];
      two_pages = page0 != page1;
      cur_page  = half_ff ? page1 : page0;
      case (job_ff.style)
         STYLE_GLYPH: pattern = glyph_column(job_ff.aux[4:0], col_ff[2:0]);
         STYLE_BAR:   pattern = (col_ff < job_ff.aux) ? 8'hFF : 8'h00;
         default:     pattern = {8{job_ff.aux[0]}};
      endcase
      for (int b = 0; b < 8; b++) begin
         row_b       = {cur_page, 3'(b)};
         rel_b       = row_b - job_ff.y;
         cur_mask[b] = (rel_b < 8'(job_ff.nrows)) && ({1'b0, row_b} < 9'(DISPLAY_HEIGHT));
         cur_val[b]  = pattern[rel_b[2:0]];
      end
      col_ok    = {1'b0, col_x} < 9'(DISPLAY_WIDTH);
      lin_idx   = INDEX_W'(col_x) + INDEX_W'(cur_page) * INDEX_W'(DISPLAY_WIDTH);
      cur_addr  = lin_idx[AW-1:0];
      last_byte = half_ff | ~two_pages;
      last_col  = col_ff == job_ff.count - 8'd1;
      read_idx      = INDEX_W'(job_ff.read_index);
      read_in_range = read_idx < INDEX_W'(FRAME_BYTES);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      col_in       = col_ff;
      half_in      = half_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      val_in       = val_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = (rd_data_ff & ~mask_ff) | (val_ff & mask_ff);
      rd_en        = 1'b0;
      rd_addr      = cur_addr;
      do_advance   = 1'b0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'h00;
            if (clr_ff == AW'(FRAME_BYTES - 1)) begin
               clr_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               job_in  = q_job;
               col_in  = 8'd0;
               half_in = 1'b0;
               clr_in  = '0;
               case (q_job.kind)
                  JOB_CLEAR: state_in = ST_CLEAR;
                  JOB_DRAW:  state_in = ST_COL;
                  JOB_READ:  state_in = ST_RDBYTE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_COL: begin
            // read the byte now, merge and write it next cycle; skip bytes off screen or with no row to draw
            if (col_ok && cur_mask != 8'h00) begin
               rd_en    = 1'b1;
               addr_in  = cur_addr;
               mask_in  = cur_mask;
               val_in   = cur_val;
               state_in = ST_WR;
            end else begin
               do_advance = 1'b1;
            end
         end
         ST_WR: begin
            wr_en      = 1'b1;
            do_advance = 1'b1;
         end
         ST_RDBYTE: begin
            rd_en    = read_in_range;
            rd_addr  = read_idx[AW-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_fit  = job_ff.fit;
               rsp_data_in.read_data = (job_ff.kind == JOB_READ && read_in_range) ?
                                       rd_data_ff : 8'h00;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (do_advance) begin
         if (!last_byte) begin
            half_in  = 1'b1;
            state_in = ST_COL;
         end else begin
            half_in = 1'b0;
            if (last_col) begin
               state_in = ST_DONE;
            end else begin
               col_in   = col_ff + 8'd1;
               state_in = ST_COL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         col_ff       <= 8'd0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // frame memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[src/ptbd_checker.sv]
// port-level checks for the page framebuffer draw engine and their binding
module ptbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ptbd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ptbd_pkg::rsp_type rsp_data
);
   import ptbd_pkg::*;

   // intake is held off straight out of reset, while the frame is being cleared
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken during post-reset clear");

   // no result can be pending straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled request stays and holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // a stalled result stays and holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result carries both a char fit and nonzero read data
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.char_fit && rsp_data.read_data != 8'h00))
      else $error("result carries both read data and char fit");

endmodule

bind page_framebuffer_text_bar_draw ptbd_checker u_ptbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
